>>> rtl/moving_average_spread_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for moving_average_spread
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_SPREAD_MACROS_SVH
`define MOVING_AVERAGE_SPREAD_MACROS_SVH

// same-cycle implication
`define MAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg
// Fixed widths and limits shared by the moving average spread block.
// ----------------------------------------------------------------------------
package mas_pkg;

	localparam int SPREAD_W  = 16;   // result width, saturating
	localparam int CFG_W     = 7;    // window length register width
	localparam int SEEN_W    = 7;    // sample counter width
	localparam int SEEN_MAX  = 127;  // sample counter saturates here

	typedef logic [CFG_W-1:0]    len_t;
	typedef logic [SEEN_W-1:0]   seen_t;
	typedef logic [SPREAD_W-1:0] spread_t;

endpackage

>>> rtl/mas_if.sv
// ----------------------------------------------------------------------------
// mas_if
// Valid/ready channels for sample words in and spread words out.
// ----------------------------------------------------------------------------
interface mas_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mas_out_if import mas_pkg::*; ();
	logic    valid;
	logic    ready;
	spread_t spread;
	logic    too_short;

	modport source (output valid, output spread, output too_short, input ready);
	modport sink   (input valid, input spread, input too_short, output ready);
endinterface

>>> rtl/mas_div.sv
// ----------------------------------------------------------------------------
// mas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mas_div #(
	parameter int DW = 24,
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;     // dividend shifting out, quotient shifting in
	logic [VW:0]   rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [VW:0] rem_sh;
	logic [VW:0] rem_sub;
	logic        ge;

	assign rem_sh  = {rem_q[VW-1:0], dq_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub : rem_sh;
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

>>> rtl/moving_average_spread.sv
// ----------------------------------------------------------------------------
// moving_average_spread
// Peak-to-peak spread of a k-sample moving average over a sample sequence.
// ----------------------------------------------------------------------------
// Each accepted sample is written to a circular sample memory, then the window
// sum is rebuilt by one adder walking back over the last n = min(samples seen,
// k) entries, one memory read per cycle. An ordinary sample goes through its
// accept, the read/accumulate pass and the extreme update before the next
// accept. A sample marked last adds a DW-bit bit-serial division of (max sum -
// min sum) by k, DW being max(SAMPLE_BITS + 7, 17), or skips it when the
// sequence held no full window, plus any wait for the previous result word to
// be taken. k is window_len clamped to 1..min(WINDOW_MAX, SEEN_MAX) and is
// sampled with every accepted item, so a write to window_len applies from the
// next accepted sample. A sequence with no full window returns spread 0 and
// too_short set. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "moving_average_spread_macros.svh"

module moving_average_spread import mas_pkg::*; #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  len_t        cfg_wdata,
	mas_in_if.sink      din,
	mas_out_if.source   dout
);

	localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_W = SAMPLE_BITS + SEEN_W;
	localparam int DIV_W = (SUM_W > SPREAD_W) ? SUM_W : SPREAD_W + 1;
	localparam int KMAX  = (WINDOW_MAX < SEEN_MAX) ? WINDOW_MAX : SEEN_MAX;

	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_MAX - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIVS = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]              state_q;
	len_t                    wl_q;
	logic [AW-1:0]           wslot_q;
	logic [AW-1:0]           ptr_q;
	seen_t                   seen_q;
	len_t                    k_q;
	seen_t                   cnt_q;
	logic                    last_q;
	logic                    full_q;
	logic                    ext_vld_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] max_q;
	logic signed [SUM_W-1:0] min_q;
	logic [SAMPLE_BITS-1:0]  rd_q;
	logic                    rd_vld_q;
	spread_t                 res_spread_q;
	logic                    res_short_q;
	logic                    out_vld_q;
	spread_t                 out_spread_q;
	logic                    out_short_q;

	logic [SAMPLE_BITS-1:0] mem_q [WINDOW_MAX];

	logic                    accept;
	len_t                    k;
	seen_t                   seen_nx;
	seen_t                   n;
	logic signed [SUM_W-1:0] rd_ext;
	logic                    div_start;
	logic                    div_done;
	logic [DIV_W-1:0]        div_q;
	logic [DIV_W-1:0]        diff;
	logic                    out_free;

	assign accept   = din.valid && din.ready;
	assign out_free = !out_vld_q || dout.ready;

	// clamp the window length to 1..min(WINDOW_MAX, SEEN_MAX)
	always_comb begin
		priority if (wl_q == '0)
			k = len_t'(1);
		else if (int'(wl_q) > KMAX)
			k = len_t'(KMAX);
		else
			k = wl_q;
	end

	assign seen_nx = (seen_q == seen_t'(SEEN_MAX)) ? seen_q : seen_q + 1'b1;
	assign n       = (seen_nx < k) ? seen_nx : k;
	assign rd_ext  = {{(SUM_W - SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
	assign diff    = DIV_W'(unsigned'(max_q - min_q));

	assign div_start = (state_q == ST_DIVS);

	mas_div #(
		.DW (DIV_W),
		.VW (CFG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (k_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= len_t'(1);
		end else if (cfg_we) begin
			wl_q <= cfg_wdata;
		end
	end

	// sample memory: write on accept, registered read
	always_ff @(posedge clk) begin
		if (accept)
			mem_q[wslot_q] <= din.sample;
		rd_q <= mem_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wslot_q   <= '0;
			ptr_q     <= '0;
			seen_q    <= '0;
			k_q       <= len_t'(1);
			cnt_q     <= '0;
			last_q    <= 1'b0;
			full_q    <= 1'b0;
			ext_vld_q <= 1'b0;
			sum_q     <= '0;
			max_q     <= '0;
			min_q     <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wslot_q <= (wslot_q == LAST_ADDR) ? '0 : wslot_q + 1'b1;
						ptr_q   <= wslot_q;
						seen_q  <= seen_nx;
						k_q     <= k;
						cnt_q   <= n;
						last_q  <= din.last;
						full_q  <= seen_nx >= k;
						sum_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// issue one read and fold in the previous one
					if (cnt_q != '0) begin
						ptr_q <= (ptr_q == '0) ? LAST_ADDR : ptr_q - 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end
					rd_vld_q <= (cnt_q != '0);
					if (rd_vld_q)
						sum_q <= sum_q + rd_ext;
					if (cnt_q == '0 && !rd_vld_q)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (full_q) begin
						ext_vld_q <= 1'b1;
						if (!ext_vld_q || sum_q > max_q)
							max_q <= sum_q;
						if (!ext_vld_q || sum_q < min_q)
							min_q <= sum_q;
					end
					priority if (!last_q)
						state_q <= ST_IDLE;
					else if (ext_vld_q || full_q)
						state_q <= ST_DIVS;
					else
						state_q <= ST_FIN;
				end
				ST_DIVS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					// drop the sequence once the result word is loaded
					if (out_free) begin
						wslot_q   <= '0;
						seen_q    <= '0;
						ext_vld_q <= 1'b0;
						max_q     <= '0;
						min_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result staging: short sequence set in UPD, quotient saturated on done
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			res_spread_q <= '0;
			res_short_q  <= !(ext_vld_q || full_q);
		end else if (div_done) begin
			res_spread_q <= (|div_q[DIV_W-1:SPREAD_W]) ? '1 : div_q[SPREAD_W-1:0];
			res_short_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			priority if (state_q == ST_FIN && out_free)
				out_vld_q <= 1'b1;
			else if (dout.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_spread_q <= res_spread_q;
			out_short_q  <= res_short_q;
		end
	end

	assign din.ready      = (state_q == ST_IDLE);
	assign dout.valid     = out_vld_q;
	assign dout.spread    = out_spread_q;
	assign dout.too_short = out_short_q;

	`MAS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !din.ready, "ready after accept")
	`MAS_ASSERT_NOW(a_short_zero, clk, arst_n, dout.valid && dout.too_short, dout.spread == '0, "short result with nonzero spread")
	`MAS_ASSERT_NOW(a_extreme_order, clk, arst_n, ext_vld_q, max_q >= min_q, "max sum below min sum")
	`MAS_ASSERT_NOW(a_cnt_in_window, clk, arst_n, state_q == ST_SUM, cnt_q <= k_q, "read count beyond window")
	`MAS_ASSERT_NOW(a_div_done_state, clk, arst_n, div_done, state_q == ST_DIV, "divider done outside divide")

endmodule
